// ----- hdl/iap_pkg.sv -----
// Shared types and constants of the integer ALU with power.
`default_nettype none

package iap_pkg;

   // Default operand and result width.
   localparam int DATA_WIDTH = 32;

   // Width of the opcode field.
   localparam int TYPE_WIDTH = 4;

   // Opcodes; codes 10 to 15 have no meaning and give a zero result.
   typedef enum logic [TYPE_WIDTH-1:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_POW = 4'd5,
      OP_AND = 4'd6,
      OP_XOR = 4'd7,
      OP_OR  = 4'd8,
      OP_ABS = 4'd9
   } iap_op_type;

   // Sequencer states of the engine.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_MUL,
      ST_POW,
      ST_ABSA,
      ST_ABSB,
      ST_DIV,
      ST_FIX,
      ST_DONE
   } iap_state_type;

   // What a finished multiplication feeds.
   typedef enum logic [1:0] {
      MK_PLAIN,
      MK_ACC,
      MK_SQR
   } iap_mul_kind_type;

   // Command from the front end to the engine.
   typedef struct packed {
      logic       start;
      iap_op_type op;
   } iap_cmd_type;

   // Status from the engine to the front end.
   typedef struct packed {
      logic idle;
      logic done;
      logic divide_by_zero;
   } iap_sts_type;

endpackage

`default_nettype wire

// ----- hdl/iap_engine.sv -----
// Sequencer and shared adder that compute one ALU operation at a time.
`default_nettype none

module iap_engine #(
   parameter int DATA_WIDTH = iap_pkg::DATA_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire iap_pkg::iap_cmd_type   cmd,
   input  wire logic [DATA_WIDTH-1:0]  operand_a,
   input  wire logic [DATA_WIDTH-1:0]  operand_b,
   input  wire logic                   out_ready,
   output iap_pkg::iap_sts_type        sts,
   output logic [DATA_WIDTH-1:0]       result_value
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH);

   iap_pkg::iap_state_type    state_ff, state_in;
   iap_pkg::iap_op_type       op_ff, op_in;
   iap_pkg::iap_mul_kind_type kind_ff, kind_in;
   logic [W-1:0]  prod_ff, prod_in;
   logic [W-1:0]  mcand_ff, mcand_in;
   logic [W-1:0]  mplier_ff, mplier_in;
   logic [W-1:0]  base_ff, base_in;
   logic [W-1:0]  exp_ff, exp_in;
   logic [W-1:0]  res_ff, res_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic          dz_ff, dz_in;

   // Shared adder/subtractor; bit W of a subtraction is the borrow.
   logic [W:0]   add_x, add_y, add_sum;
   logic         add_sub;
   logic [W-1:0] div_shift;

   assign div_shift = {prod_ff[W-2:0], mplier_ff[W-1]};
   assign add_sum   = add_x + (add_sub ? ~add_y : add_y) + {{W{1'b0}}, add_sub};

   // Operand selection for the shared adder.
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         iap_pkg::ST_ADD: begin
            add_x   = {1'b0, mcand_ff};
            add_y   = {1'b0, mplier_ff};
            add_sub = (op_ff == iap_pkg::OP_SUB);
         end
         iap_pkg::ST_MUL: begin
            add_x = {1'b0, prod_ff};
            add_y = {1'b0, mcand_ff};
         end
         iap_pkg::ST_ABSA: begin
            add_y   = {1'b0, mplier_ff};
            add_sub = 1'b1;
         end
         iap_pkg::ST_ABSB: begin
            add_y   = {1'b0, mcand_ff};
            add_sub = 1'b1;
         end
         iap_pkg::ST_DIV: begin
            add_x   = {1'b0, div_shift};
            add_y   = {1'b0, mcand_ff};
            add_sub = 1'b1;
         end
         iap_pkg::ST_FIX: begin
            add_y   = (op_ff == iap_pkg::OP_MOD) ? {1'b0, prod_ff} : {1'b0, mplier_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   // Next state and datapath updates.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      kind_in   = kind_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      res_in    = res_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      dz_in     = dz_ff;

      unique case (state_ff)
         iap_pkg::ST_IDLE: begin
            if (cmd.start) begin
               op_in = cmd.op;
               dz_in = 1'b0;
               unique case (cmd.op)
                  iap_pkg::OP_ADD, iap_pkg::OP_SUB: begin
                     mcand_in  = operand_a;
                     mplier_in = operand_b;
                     state_in  = iap_pkg::ST_ADD;
                  end
                  iap_pkg::OP_MUL: begin
                     prod_in   = '0;
                     mcand_in  = operand_a;
                     mplier_in = operand_b;
                     kind_in   = iap_pkg::MK_PLAIN;
                     state_in  = iap_pkg::ST_MUL;
                  end
                  iap_pkg::OP_DIV, iap_pkg::OP_MOD: begin
                     if (operand_b == '0) begin
                        // A zero divisor flags the error and gives zero.
                        res_in   = '0;
                        dz_in    = 1'b1;
                        state_in = iap_pkg::ST_DONE;
                     end else begin
                        mplier_in = operand_a;
                        mcand_in  = operand_b;
                        prod_in   = '0;
                        neg_in    = (cmd.op == iap_pkg::OP_DIV) ?
                                    (operand_a[W-1] ^ operand_b[W-1]) : operand_a[W-1];
                        cnt_in    = CW'(W - 1);
                        state_in  = iap_pkg::ST_ABSA;
                     end
                  end
                  iap_pkg::OP_POW: begin
                     if (operand_b[W-1]) begin
                        // A negative exponent gives zero.
                        res_in   = '0;
                        state_in = iap_pkg::ST_DONE;
                     end else begin
                        res_in   = W'(1);
                        base_in  = operand_a;
                        exp_in   = operand_b;
                        state_in = iap_pkg::ST_POW;
                     end
                  end
                  iap_pkg::OP_AND: begin
                     res_in   = operand_a & operand_b;
                     state_in = iap_pkg::ST_DONE;
                  end
                  iap_pkg::OP_XOR: begin
                     res_in   = operand_a ^ operand_b;
                     state_in = iap_pkg::ST_DONE;
                  end
                  iap_pkg::OP_OR: begin
                     res_in   = operand_a | operand_b;
                     state_in = iap_pkg::ST_DONE;
                  end
                  iap_pkg::OP_ABS: begin
                     mplier_in = operand_a;
                     neg_in    = operand_a[W-1];
                     state_in  = iap_pkg::ST_FIX;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = iap_pkg::ST_DONE;
                  end
               endcase
            end
         end

         iap_pkg::ST_ADD: begin
            res_in   = add_sum[W-1:0];
            state_in = iap_pkg::ST_DONE;
         end

         // Shift-and-add multiply, low half only; stops once no multiplier bits remain.
         iap_pkg::ST_MUL: begin
            if (mplier_ff == '0) begin
               unique case (kind_ff)
                  iap_pkg::MK_PLAIN: begin
                     res_in   = prod_ff;
                     state_in = iap_pkg::ST_DONE;
                  end
                  iap_pkg::MK_ACC: begin
                     res_in   = prod_ff;
                     exp_in   = {exp_ff[W-1:1], 1'b0};
                     state_in = iap_pkg::ST_POW;
                  end
                  iap_pkg::MK_SQR: begin
                     base_in  = prod_ff;
                     state_in = iap_pkg::ST_POW;
                  end
                  default: begin
                     state_in = iap_pkg::ST_DONE;
                  end
               endcase
            end else begin
               if (mplier_ff[0]) begin
                  prod_in = add_sum[W-1:0];
               end
               mcand_in  = {mcand_ff[W-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[W-1:1]};
            end
         end

         // Square-and-multiply step: multiply in a set low bit, else square the base.
         iap_pkg::ST_POW: begin
            if (exp_ff == '0) begin
               state_in = iap_pkg::ST_DONE;
            end else if (exp_ff[0]) begin
               prod_in   = '0;
               mcand_in  = res_ff;
               mplier_in = base_ff;
               kind_in   = iap_pkg::MK_ACC;
               state_in  = iap_pkg::ST_MUL;
            end else begin
               exp_in    = {1'b0, exp_ff[W-1:1]};
               prod_in   = '0;
               mcand_in  = base_ff;
               mplier_in = base_ff;
               kind_in   = iap_pkg::MK_SQR;
               state_in  = iap_pkg::ST_MUL;
            end
         end

         // Magnitude of the dividend.
         iap_pkg::ST_ABSA: begin
            if (mplier_ff[W-1]) begin
               mplier_in = add_sum[W-1:0];
            end
            state_in = iap_pkg::ST_ABSB;
         end

         // Magnitude of the divisor.
         iap_pkg::ST_ABSB: begin
            if (mcand_ff[W-1]) begin
               mcand_in = add_sum[W-1:0];
            end
            state_in = iap_pkg::ST_DIV;
         end

         // Restoring division, one quotient bit per cycle.
         iap_pkg::ST_DIV: begin
            if (!add_sum[W]) begin
               prod_in   = add_sum[W-1:0];
               mplier_in = {mplier_ff[W-2:0], 1'b1};
            end else begin
               prod_in   = div_shift;
               mplier_in = {mplier_ff[W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = iap_pkg::ST_FIX;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end

         // Apply the sign to a quotient, remainder or absolute value.
         iap_pkg::ST_FIX: begin
            res_in   = neg_ff ? add_sum[W-1:0] : add_y[W-1:0];
            state_in = iap_pkg::ST_DONE;
         end

         iap_pkg::ST_DONE: begin
            if (out_ready) begin
               state_in = iap_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = iap_pkg::ST_IDLE;
         end
      endcase
   end

   // Status toward the front end comes straight from the registers.
   assign sts = '{idle:           (state_ff == iap_pkg::ST_IDLE),
                  done:           (state_ff == iap_pkg::ST_DONE),
                  divide_by_zero: dz_ff};
   assign result_value = res_ff;

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iap_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      kind_ff   <= kind_in;
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      res_ff    <= res_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      dz_ff     <= dz_in;
   end

endmodule

`default_nettype wire

// ----- hdl/integer_alu_with_power_core.sv -----
// Top level of the integer ALU with power: stream ports and the result register.
`default_nettype none

// Integer ALU over DATA_WIDTH-bit two's complement operands: add, subtract,
// multiply, divide toward zero, remainder with the dividend's sign, power by
// square-and-multiply, AND, XOR, OR and absolute value, all wrapping modulo
// 2^DATA_WIDTH. A zero divisor gives 0 with divide_by_zero set; a negative
// exponent gives 0. One transaction is processed at a time by a single
// adder/subtractor under a sequencer, so the cost per transaction (accept to
// next accept) depends on the operation. Divide and remainder take one
// quotient bit per cycle. Power runs one shift-and-add multiplication per
// exponent bit but the highest for the square and one more per set bit.
// A finished result waits in an output register, so a stalled result side
// holds the engine only after the next operation completes.
module integer_alu_with_power_core #(
   parameter int DATA_WIDTH = iap_pkg::DATA_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: req_type [3:0], operand_a, operand_b, zero padding.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [((iap_pkg::TYPE_WIDTH + 2*DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // rsp_tdata: result_value, zero padding.
   output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // rsp_tuser: divide_by_zero.
   output logic                        rsp_tuser
);

   localparam int TW    = iap_pkg::TYPE_WIDTH;
   localparam int RSP_W = ((DATA_WIDTH + 7) / 8) * 8;

   iap_pkg::iap_cmd_type  cmd;
   iap_pkg::iap_sts_type  sts;
   logic [DATA_WIDTH-1:0] eng_result;
   logic                  out_ready;
   logic                  load;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_dz_ff, rsp_dz_in;

   // Unpack the request transaction into a command.
   assign req_tready = sts.idle;
   assign cmd.start  = req_tvalid & req_tready;
   assign cmd.op     = iap_pkg::iap_op_type'(req_tdata[TW-1:0]);

   iap_engine #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .operand_a    (req_tdata[TW +: DATA_WIDTH]),
      .operand_b    (req_tdata[TW + DATA_WIDTH +: DATA_WIDTH]),
      .out_ready    (out_ready),
      .sts          (sts),
      .result_value (eng_result)
   );

   // The output register takes a new result when it is empty or being drained.
   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign load      = sts.done && out_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_dz_in    = rsp_dz_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
         rsp_dz_in    = sts.divide_by_zero;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_dz_ff   <= rsp_dz_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_dz_ff;

endmodule

`default_nettype wire

// ----- tb/sv/integer_alu_with_power_core_tb.sv -----
// Self-checking testbench for the integer ALU with power: directed table, then random traffic.
`default_nettype none

module integer_alu_with_power_core_tb;

   localparam int W     = iap_pkg::DATA_WIDTH;
   localparam int TW    = iap_pkg::TYPE_WIDTH;
   localparam int REQ_W = ((TW + 2 * W + 7) / 8) * 8;
   localparam int RSP_W = ((W + 7) / 8) * 8;

   // Opcodes without a meaning: the block answers them with zero.
   localparam logic [TW-1:0] OP_UNUSED_LO = 4'd10;
   localparam logic [TW-1:0] OP_UNUSED_HI = 4'd15;

   // Operand extremes.
   localparam logic [W-1:0] S_MIN  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] S_MAX  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] S_NEG1 = '1;

   // A table row either carries its answer or leaves it to the predictor.
   localparam logic CHECK_TYPED = 1'b1;
   localparam logic CHECK_MODEL = 1'b0;

   localparam int RANDOM_ITEMS   = 800;
   localparam int QUIET_FROM     = 700;   // no idling on either side from here on
   localparam int HOLD_AT        = 150;   // item at which the receiver starts its long hold
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 100;
   // A full-length power is by far the slowest transaction; the run has a few dozen of them at most,
   // and the limit also has to cover everything else, including stalls.
   localparam int CYCLE_LIMIT    = 600000;

   typedef struct packed {
      logic [W-1:0] value;
      logic         div_zero;
   } alu_result_type;

   typedef struct packed {
      logic [TW-1:0] op;
      logic [W-1:0]  a;
      logic [W-1:0]  b;
      logic          typed;
      logic [W-1:0]  value;
      logic          div_zero;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 25;

   // Extremes, every opcode and each special case; typed answers where they are obvious.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{iap_pkg::OP_ADD, S_MAX, 32'd1, CHECK_TYPED, S_MIN, 1'b0},
      '{iap_pkg::OP_ADD, S_MIN, S_MIN, CHECK_TYPED, 32'd0, 1'b0},
      '{iap_pkg::OP_SUB, S_MIN, 32'd1, CHECK_TYPED, S_MAX, 1'b0},
      '{iap_pkg::OP_SUB, 32'd0, S_MIN, CHECK_TYPED, S_MIN, 1'b0},
      '{iap_pkg::OP_MUL, S_MAX, S_MAX, CHECK_TYPED, 32'd1, 1'b0},
      '{iap_pkg::OP_MUL, S_NEG1, S_MIN, CHECK_TYPED, S_MIN, 1'b0},
      '{iap_pkg::OP_DIV, 32'd7, 32'hFFFF_FFFE, CHECK_TYPED, 32'hFFFF_FFFD, 1'b0},
      '{iap_pkg::OP_DIV, S_MIN, S_NEG1, CHECK_TYPED, S_MIN, 1'b0},
      '{iap_pkg::OP_DIV, 32'h1234_5678, 32'd0, CHECK_TYPED, 32'd0, 1'b1},
      '{iap_pkg::OP_DIV, 32'd0, S_MIN, CHECK_MODEL, 32'd0, 1'b0},
      '{iap_pkg::OP_MOD, 32'hFFFF_FFF9, 32'd2, CHECK_TYPED, S_NEG1, 1'b0},
      '{iap_pkg::OP_MOD, S_MIN, S_NEG1, CHECK_TYPED, 32'd0, 1'b0},
      '{iap_pkg::OP_MOD, S_MAX, 32'd0, CHECK_TYPED, 32'd0, 1'b1},
      '{iap_pkg::OP_POW, 32'd3, S_NEG1, CHECK_TYPED, 32'd0, 1'b0},
      '{iap_pkg::OP_POW, 32'd0, 32'd0, CHECK_TYPED, 32'd1, 1'b0},
      '{iap_pkg::OP_POW, 32'd2, 32'd31, CHECK_TYPED, S_MIN, 1'b0},
      '{iap_pkg::OP_POW, S_NEG1, S_MAX, CHECK_TYPED, S_NEG1, 1'b0},
      '{iap_pkg::OP_POW, 32'd3, S_MAX, CHECK_MODEL, 32'd0, 1'b0},
      '{iap_pkg::OP_AND, 32'hF0F0_F0F0, 32'hFF00_FF00, CHECK_MODEL, 32'd0, 1'b0},
      '{iap_pkg::OP_XOR, S_NEG1, 32'h5555_AAAA, CHECK_MODEL, 32'd0, 1'b0},
      '{iap_pkg::OP_OR, 32'd0, S_MIN, CHECK_TYPED, S_MIN, 1'b0},
      '{iap_pkg::OP_ABS, S_MIN, 32'd0, CHECK_TYPED, S_MIN, 1'b0},
      '{iap_pkg::OP_ABS, 32'hFFFF_FFFB, S_MAX, CHECK_TYPED, 32'd5, 1'b0},
      '{OP_UNUSED_LO, S_MAX, S_MAX, CHECK_TYPED, 32'd0, 1'b0},
      '{OP_UNUSED_HI, S_NEG1, S_NEG1, CHECK_TYPED, 32'd0, 1'b0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;

   alu_result_type pending_results [$];
   alu_result_type oldest_result;
   int             failures = 0;
   int             cycle_count = 0;
   bit             quiet = 1'b0;
   bit             long_hold_pending = 1'b0;

   integer_alu_with_power_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a period of 12 time units.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicts the answer to one transaction, everything wrapping modulo 2^W.
   function automatic alu_result_type alu_outcome(input logic [TW-1:0] op,
                                                  input logic [W-1:0] a, input logic [W-1:0] b);
      alu_result_type r;
      logic [W-1:0]   mag_a;
      logic [W-1:0]   mag_b;
      logic [W-1:0]   part;
      logic [W-1:0]   base;
      logic [W-1:0]   exponent;
      logic [W-1:0]   acc;
      r.value    = '0;
      r.div_zero = 1'b0;
      case (op)
         iap_pkg::OP_ADD: r.value = a + b;
         iap_pkg::OP_SUB: r.value = a - b;
         iap_pkg::OP_MUL: r.value = a * b;
         iap_pkg::OP_DIV, iap_pkg::OP_MOD: begin
            if (b == '0) begin
               r.div_zero = 1'b1;
            end else begin
               mag_a = a[W-1] ? -a : a;
               mag_b = b[W-1] ? -b : b;
               if (op == iap_pkg::OP_DIV) begin
                  part    = mag_a / mag_b;
                  r.value = (a[W-1] != b[W-1]) ? -part : part;
               end else begin
                  part    = mag_a % mag_b;
                  r.value = a[W-1] ? -part : part;
               end
            end
         end
         iap_pkg::OP_POW: begin
            // Square and multiply; a negative exponent leaves the result at zero.
            if (!b[W-1]) begin
               acc      = W'(1);
               base     = a;
               exponent = b;
               while (exponent != '0) begin
                  if (exponent[0])
                     acc = acc * base;
                  exponent = exponent >> 1;
                  base     = base * base;
               end
               r.value = acc;
            end
         end
         iap_pkg::OP_AND: r.value = a & b;
         iap_pkg::OP_XOR: r.value = a ^ b;
         iap_pkg::OP_OR:  r.value = a | b;
         iap_pkg::OP_ABS: r.value = a[W-1] ? -a : a;
         default: r.value = '0;
      endcase
      return r;
   endfunction

   // Operand mix: extremes, small signed values and full-range values.
   function automatic logic [W-1:0] random_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return W'(1);
         2: return S_NEG1;
         3: return S_MIN;
         4: return S_MAX;
         5, 6: return W'($urandom_range(0, 511)) - W'(256);
         default: return W'($urandom());
      endcase
   endfunction

   // Offers one transaction, waits for the handshake and records the expected answer.
   task automatic offer_operation(input logic [TW-1:0] op, input logic [W-1:0] a,
                                  input logic [W-1:0] b, input alu_result_type answer);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({b, a, op});
      do
         @(posedge clock);
      while (!req_tready);
      pending_results.push_back(answer);
   endtask

   // Result side: random stalls, one long hold when asked, and steady acceptance at the end.
   initial begin
      @(negedge reset);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Compare each result transaction with the oldest expected answer.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result_value %0h arrived with no transaction outstanding", rsp_tdata[W-1:0]);
            failures++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_tdata[W-1:0] !== oldest_result.value) begin
               $error("result_value: expected %0h, actual %0h",
                      oldest_result.value, rsp_tdata[W-1:0]);
               failures++;
            end
            if (rsp_tuser !== oldest_result.div_zero) begin
               $error("divide_by_zero: expected %0b, actual %0b",
                      oldest_result.div_zero, rsp_tuser);
               failures++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Reset, directed table, random traffic, drain and verdict.
   initial begin
      directed_row_type row;
      logic [TW-1:0]    op;
      logic [W-1:0]     a;
      logic [W-1:0]     b;
      alu_result_type   answer;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.typed)
            answer = '{value: row.value, div_zero: row.div_zero};
         else
            answer = alu_outcome(row.op, row.a, row.b);
         offer_operation(row.op, row.a, row.b, answer);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == HOLD_AT)
            long_hold_pending = 1'b1;
         if (i == QUIET_FROM)
            quiet = 1'b1;
         if ($urandom_range(0, 39) == 0)
            op = TW'($urandom_range(10, 15));
         else
            op = TW'($urandom_range(0, 9));
         a = random_operand();
         // Long exponents are slow, so most powers use short ones.
         if (op == iap_pkg::OP_POW && $urandom_range(0, 11) != 0)
            b = W'($urandom_range(0, 40));
         else
            b = random_operand();
         offer_operation(op, a, b, alu_outcome(op, a, b));
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
